// ===== src/ipv6ck_pkg.sv =====
// Package: shared types and constants for the IPv6 upper-layer checksum unit.
`default_nettype none
package ipv6ck_pkg;

  localparam logic [15:0] SumAllOnes      = 16'hFFFF;
  localparam logic [15:0] TailMask        = 16'hFF00;
  localparam logic [15:0] AddrBytes       = 16'd32;
  localparam logic [7:0]  NextHeaderReset = 8'd17;

  // One word held in the input register
  typedef struct packed {
    logic        valid;
    logic [15:0] data_word;
    logic        single_byte;
    logic        last;
  } stage_t;

endpackage
`default_nettype wire

// ===== src/ipv6ck_if.sv =====
// Interfaces: input word channel and checksum result channel.
`default_nettype none
interface ipv6ck_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] data_word;
  logic        single_byte;
  logic        last;

  modport source (output valid, output data_word, output single_byte, output last,
                  input ready);
  modport sink   (input valid, input data_word, input single_byte, input last,
                  output ready);
endinterface

interface ipv6ck_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum_value;
  logic [15:0] segment_length;

  modport source (output valid, output checksum_value, output segment_length,
                  input ready);
  modport sink   (input valid, input checksum_value, input segment_length,
                  output ready);
endinterface
`default_nettype wire

// ===== src/ipv6ck_in_reg.sv =====
// Input register: captures one word transaction per cycle while it is empty or while the held word moves on.
`default_nettype none
module ipv6ck_in_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [15:0]      in_data_word,
  input  wire logic             in_single_byte,
  input  wire logic             in_last,
  output logic                  in_ready,
  input  wire logic             advance,
  output ipv6ck_pkg::stage_t    stage
);
  import ipv6ck_pkg::*;

  logic        valid_r;
  logic [15:0] word_r;
  logic        odd_r;
  logic        last_r;

  // Accept when empty or when the held word moves on this cycle
  assign in_ready = !valid_r || advance;

  // Hold the control bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // Load the payload on each accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_data_word;
      odd_r  <= in_single_byte;
      last_r <= in_last;
    end
  end

  assign stage.valid       = valid_r;
  assign stage.data_word   = word_r;
  assign stage.single_byte = odd_r;
  assign stage.last        = last_r;
endmodule
`default_nettype wire

// ===== src/ipv6ck_accum.sv =====
// Accumulator: running ones'-complement sum, byte count and result register.
`default_nettype none
module ipv6ck_accum (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [7:0]       cfg_wr_data,
  input  wire ipv6ck_pkg::stage_t stage,
  output logic                  advance,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [15:0]           out_checksum_value,
  output logic [15:0]           out_segment_length
);
  import ipv6ck_pkg::*;

  logic [7:0]  proto_r;
  logic [15:0] sum_r;
  logic [15:0] cnt_r;
  logic        out_valid_r;
  logic [15:0] csum_r;
  logic [15:0] seg_r;

  logic        can_out;
  logic [15:0] word_m;
  logic [15:0] cnt_nxt;
  logic [16:0] part;
  logic [15:0] sum_nxt;
  logic [15:0] seg;
  logic [17:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] csum_nxt;

  // Move the held word on unless it needs a full result register
  assign can_out = !out_valid_r || out_ready;
  assign advance = stage.valid && (!stage.last || can_out);

  // Drop the low byte of an odd tail and count the bytes
  assign word_m  = stage.single_byte ? (stage.data_word & TailMask) : stage.data_word;
  assign cnt_nxt = cnt_r + (stage.single_byte ? 16'd1 : 16'd2);

  // Running sum with end-around carry
  assign part    = {1'b0, sum_r} + {1'b0, word_m};
  assign sum_nxt = part[15:0] + {15'd0, part[16]};

  // Segment length is the count past the address bytes
  assign seg = (cnt_nxt >= AddrBytes) ? (cnt_nxt - AddrBytes) : 16'd0;

  // Add word, length and protocol number at once, then fold twice
  assign total = {2'b00, sum_r} + {2'b00, word_m} + {2'b00, seg}
               + {10'd0, proto_r};
  assign fold1 = {1'b0, total[15:0]} + {15'd0, total[17:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  // Complement unless the folded sum is all ones
  assign csum_nxt = (fold2 != SumAllOnes) ? ~fold2 : fold2;

  // Hold configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_r     <= NextHeaderReset;
      sum_r       <= 16'd0;
      cnt_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        proto_r <= cfg_wr_data;
      end
      if (advance) begin
        if (stage.last) begin
          sum_r <= 16'd0;
          cnt_r <= 16'd0;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_nxt;
        end
      end
      if (advance && stage.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (advance && stage.last) begin
      csum_r <= csum_nxt;
      seg_r  <= seg;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_checksum_value = csum_r;
  assign out_segment_length = seg_r;
endmodule
`default_nettype wire

// ===== src/ipv6_upper_layer_checksum_unit.sv =====
// Top level: IPv6 upper-layer checksum over a stream of 16-bit words.
// A word marked last passes the input register and then the result register before it is offered as a result.
// Throughput: one word per cycle; the input and result registers hold one word each,
// and only a full result register with a last word behind it stalls the input.
// Reset (rst_n low at a clock edge) empties both registers, clears the running sum
// and byte count, and sets the protocol register to 17.
`default_nettype none
module ipv6_upper_layer_checksum_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  ipv6ck_in_if.sink           in_ch,
  ipv6ck_out_if.source        out_ch,
  input  wire logic           cfg_wr_en,
  input  wire logic [7:0]     cfg_wr_data
);
  import ipv6ck_pkg::*;

  stage_t stage;
  logic   advance;

  ipv6ck_in_reg u_in_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_data_word   (in_ch.data_word),
    .in_single_byte (in_ch.single_byte),
    .in_last        (in_ch.last),
    .in_ready       (in_ch.ready),
    .advance        (advance),
    .stage          (stage)
  );

  ipv6ck_accum u_accum (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .stage              (stage),
    .advance            (advance),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_checksum_value (out_ch.checksum_value),
    .out_segment_length (out_ch.segment_length)
  );
endmodule
`default_nettype wire

// ===== src/ipv6ck_checker.sv =====
// Checker: port-level assertions for the checksum unit, with its bind.
`default_nettype none
module ipv6ck_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_checksum_value,
  input wire logic [15:0] out_segment_length
);
  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_checksum_value)
                                && $stable(out_segment_length))
    else $error("result payload changed while stalled");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result offered right after reset");

  // A complement of zero goes out as all ones, so zero never appears
  a_no_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_checksum_value != 16'h0000)
    else $error("checksum value of zero");
endmodule

bind ipv6_upper_layer_checksum_unit ipv6ck_checker u_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_checksum_value (out_ch.checksum_value),
  .out_segment_length (out_ch.segment_length)
);
`default_nettype wire

// ===== dv/ipv6ck_checksum_checker.sv =====
// Checker: predicts IPv6 upper-layer checksums from the word stream and compares results.
module ipv6ck_checksum_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_data_word,
  input  logic        in_single_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_checksum_value,
  input  logic [15:0] out_segment_length,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output int          fail_count,
  output int          pending_results
);
  import ipv6ck_pkg::*;

  typedef struct packed {
    logic [15:0] checksum_value;
    logic [15:0] segment_length;
  } csum_result_t;

  // Shadow of the block's configuration and packet state
  logic [7:0]   proto_cfg;
  logic [15:0]  sum_acc;
  logic [15:0]  byte_total;
  csum_result_t expected_results[$];
  csum_result_t oldest_result;

  // Ones'-complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  // Fold one accepted word into the sum; on the last word, finish the checksum
  task automatic accumulate_word(input logic [15:0] word, input logic odd, input logic fin);
    logic [15:0]  seg;
    logic [15:0]  total;
    csum_result_t res;
    if (odd) begin
      word = word & TailMask;
    end
    sum_acc    = ones_add(sum_acc, word);
    byte_total = byte_total + (odd ? 16'd1 : 16'd2);
    if (fin) begin
      seg   = (byte_total >= AddrBytes) ? byte_total - AddrBytes : 16'd0;
      total = ones_add(ones_add(sum_acc, seg), {8'h00, proto_cfg});
      res.checksum_value = (total != SumAllOnes) ? ~total : total;
      res.segment_length = seg;
      expected_results.push_back(res);
      sum_acc    = 16'd0;
      byte_total = 16'd0;
    end
  endtask

  // Compare results first: a result at this edge belongs to an earlier word
  always @(posedge clk) begin
    if (!rst_n) begin
      proto_cfg  = NextHeaderReset;
      sum_acc    = 16'd0;
      byte_total = 16'd0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: checksum 0x%04h, length 0x%04h",
                                    out_checksum_value, out_segment_length));
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_checksum_value !== oldest_result.checksum_value) begin
            report_mismatch($sformatf("checksum_value mismatch: got 0x%04h, expected 0x%04h",
                                      out_checksum_value, oldest_result.checksum_value));
          end
          if (out_segment_length !== oldest_result.segment_length) begin
            report_mismatch($sformatf("segment_length mismatch: got 0x%04h, expected 0x%04h",
                                      out_segment_length, oldest_result.segment_length));
          end
        end
      end
      if (in_valid && in_ready) begin
        accumulate_word(in_data_word, in_single_byte, in_last);
      end
      if (cfg_wr_en) begin
        proto_cfg = cfg_wr_data;
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: drives packet words and next-header writes, and reports the verdict.
module tb_top;
  import ipv6ck_pkg::*;

  localparam int WatchdogLimit  = 500;
  localparam int LongHoldCycles = 60;
  localparam int PhaseItems     = 250;
  localparam int NumPhases      = 7;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  int         fail_count;
  int         pending_results;
  int         items_sent;
  int         quiet_cycles;
  bit         send_idle;
  bit         recv_idle;
  bit         long_hold_req;

  ipv6ck_in_if  in_ch();
  ipv6ck_out_if out_ch();

  always #5 clk = ~clk;

  ipv6_upper_layer_checksum_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  ipv6ck_checksum_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_data_word       (in_ch.data_word),
    .in_single_byte     (in_ch.single_byte),
    .in_last            (in_ch.last),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_checksum_value (out_ch.checksum_value),
    .out_segment_length (out_ch.segment_length),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .fail_count         (fail_count),
    .pending_results    (pending_results)
  );

  // Offer one word after a random gap and hold it until the transaction
  task automatic send_word(input logic [15:0] word, input logic odd, input logic fin);
    int gap;
    gap = send_idle ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.data_word   <= word;
    in_ch.single_byte <= odd;
    in_ch.last        <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Send a packet of nbytes with random content; noise puts odd bytes mid-packet
  task automatic send_packet(input int nbytes, input bit noisy);
    int       nwords;
    logic     odd;
    logic     fin;
    nwords = (nbytes + 1) / 2;
    for (int w = 0; w < nwords; w++) begin
      fin = (w == nwords - 1);
      odd = fin && (nbytes % 2 == 1);
      if (noisy && !fin && $urandom_range(0, 19) == 0) begin
        odd = 1'b1;
      end
      send_word(16'($urandom()), odd, fin);
    end
  endtask

  // Drain outstanding results, let the pipe settle, then write the protocol register
  task automatic write_proto(input logic [7:0] value);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic int pick_packet_bytes(input bit tiny);
    int r;
    r = $urandom_range(0, 9);
    if (tiny) return $urandom_range(1, 6);
    if (r < 2) return $urandom_range(1, 31);
    if (r < 9) return $urandom_range(32, 120);
    return $urandom_range(121, 400);
  endfunction

  // Result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk);
      end
      stall = recv_idle ? $urandom_range(0, 4) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[ipv6_upper_layer_checksum_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] proto_values [NumPhases];
    int         phase_start;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_word   = 16'd0;
    in_ch.single_byte = 1'b0;
    in_ch.last        = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 8'd0;
    items_sent        = 0;
    quiet_cycles      = 0;
    send_idle         = 1'b0;
    recv_idle         = 1'b0;
    long_hold_req     = 1'b0;
    proto_values = '{8'd0, 8'd255, 8'($urandom()), 8'd6, 8'($urandom()), 8'd58, 8'd255};

    // Hold reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: folded sum of all ones kept as is
    send_word(16'hFFEE, 1'b0, 1'b1);
    // Extremes of a one-word short packet
    send_word(16'hFFFF, 1'b0, 1'b1);
    send_word(16'h0000, 1'b0, 1'b1);
    // Odd tail: low byte dropped
    send_word(16'hABCD, 1'b1, 1'b1);
    // Odd byte in mid-packet, no realignment afterwards
    send_word(16'h12FF, 1'b1, 1'b0);
    send_word(16'h3456, 1'b0, 1'b1);
    // Just past the address bytes, with carries on every add after the first
    for (int i = 0; i < 17; i++) begin
      send_word(16'hFFFF, 1'b0, i == 16);
    end

    // Random phases, each writing a protocol number and setting an idling mix
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_proto(proto_values[ph]);
      send_idle = (ph == 0 || ph == 2 || ph == 4 || ph == 5);
      recv_idle = (ph == 0 || ph == 3 || ph == 4 || ph == 5);
      if (ph == 4) begin
        long_hold_req = 1'b1;
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        send_packet(pick_packet_bytes(ph == 4), 1'b1);
      end
    end

    // Drain and let the pipe settle before the verdict
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ipv6_upper_layer_checksum_unit] OK");
    end else begin
      $display("[ipv6_upper_layer_checksum_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ipv6ck_pkg.sv
src/ipv6ck_if.sv
src/ipv6ck_in_reg.sv
src/ipv6ck_accum.sv
src/ipv6_upper_layer_checksum_unit.sv
src/ipv6ck_checker.sv
dv/ipv6ck_checksum_checker.sv
dv/tb_top.sv
